### rtl/irptv_pkg.sv
// Shared types and constants of the IR pulse train validator.
package irptv_pkg;

   localparam int SAMPLE_W = 10;
   localparam int TIME_W   = 32;
   localparam int MS_W     = 16;
   localparam int PEAKS_W  = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_THRESHOLD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRE_SILENCE_MS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POST_SILENCE_MS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SEQUENCE_MS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REQUIRED_PEAKS   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_TOLERANCE_MS = 3'd5;

   // Register values after reset.
   localparam logic [SAMPLE_W-1:0] RST_LEVEL_THRESHOLD  = 10'd990;
   localparam logic [MS_W-1:0]     RST_PRE_SILENCE_MS   = 16'd1000;
   localparam logic [MS_W-1:0]     RST_POST_SILENCE_MS  = 16'd1000;
   localparam logic [MS_W-1:0]     RST_MAX_SEQUENCE_MS  = 16'd1000;
   localparam logic [PEAKS_W-1:0]  RST_REQUIRED_PEAKS   = 4'd3;
   localparam logic [MS_W-1:0]     RST_GAP_TOLERANCE_MS = 16'd250;

   typedef enum logic [1:0] {
      VERDICT_NONE      = 2'd0,
      VERDICT_ACCEPTED  = 2'd1,
      VERDICT_IRREGULAR = 2'd2,
      VERDICT_ABORTED   = 2'd3
   } verdict_type;

   typedef struct packed {
      logic [MS_W-1:0]     gap_tolerance_ms;
      logic [PEAKS_W-1:0]  required_peaks;
      logic [MS_W-1:0]     max_sequence_ms;
      logic [MS_W-1:0]     post_silence_ms;
      logic [MS_W-1:0]     pre_silence_ms;
      logic [SAMPLE_W-1:0] level_threshold;
   } cfg_type;

   // One classified sample as it waits between front and back.
   typedef struct packed {
      logic                lit;
      logic [TIME_W-1:0]   time_ms;
      logic [SAMPLE_W-1:0] sample;
   } item_type;

   typedef struct packed {
      logic [TIME_W-1:0] accepted_duration;
      logic [TIME_W-1:0] accepted_start;
      verdict_type       verdict;
   } result_type;

endpackage

### rtl/irptv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module irptv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/irptv_front.sv
// Request intake: classifies each sample as lit or quiet and queues it.
module irptv_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [47:0]                        req_tdata,
   input  logic [irptv_pkg::SAMPLE_W-1:0]     level_threshold,
   output logic                               q_valid,
   output irptv_pkg::item_type                q_item,
   input  logic                               q_pop
);
   import irptv_pkg::*;

   localparam int QAW    = 1;
   localparam int QDEPTH = 2 ** QAW;

   item_type         entries_ff [QDEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]     count_ff, count_in;
   item_type         new_item;
   logic             push;

   always_comb begin
      new_item.sample  = req_tdata[SAMPLE_W-1:0];
      new_item.time_ms = req_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W];
      new_item.lit     = new_item.sample > level_threshold;
   end

   assign req_tready = count_ff < (QAW+1)'(QDEPTH);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = count_ff != '0;
   assign q_item     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

### rtl/irptv_div.sv
// Restoring divider, one quotient bit per cycle.
module irptv_div #(
   parameter int NUM_W = 36,
   parameter int DEN_W = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] acc_ff, acc_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, acc_ff[NUM_W-1]};
      fits    = trial >= {1'b0, den_ff};
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CW'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {acc_ff[NUM_W-2:0], fits};
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = acc_ff;

endmodule

### rtl/irptv_back.sv
// Sequence engine: peak detection, sequence tracking and gap validation.
module irptv_back #(
   parameter int MAX_PEAKS = 8
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  irptv_pkg::cfg_type                             cfg,
   input  logic                                           q_valid,
   input  irptv_pkg::item_type                            q_item,
   output logic                                           q_pop,
   output logic                                           div_start,
   output logic [irptv_pkg::TIME_W+$clog2(MAX_PEAKS+1)-1:0] div_num,
   output logic [$clog2(MAX_PEAKS+1)-1:0]                 div_den,
   input  logic                                           div_done,
   input  logic [irptv_pkg::TIME_W+$clog2(MAX_PEAKS+1)-1:0] div_quot,
   output logic                                           rsp_valid,
   input  logic                                           rsp_ready,
   output irptv_pkg::result_type                          rsp_result
);
   import irptv_pkg::*;

   localparam int IDX_W = $clog2(MAX_PEAKS);
   localparam int CNT_W = $clog2(MAX_PEAKS + 1);
   localparam int CMP_W = (CNT_W > PEAKS_W) ? CNT_W : PEAKS_W;
   localparam int SUM_W = TIME_W + CNT_W;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_EVAL   = 6'b000010,
      ST_WALK   = 6'b000100,
      ST_DSTART = 6'b001000,
      ST_DIV    = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   item_type            item_ff, item_in;
   logic [CNT_W-1:0]    peaks_ff, peaks_in;
   logic [TIME_W-1:0]   seq_begin_ff, seq_begin_in;
   logic [TIME_W-1:0]   silence_ff, silence_in;
   logic [SAMPLE_W-1:0] rmax_ff, rmax_in;
   logic [TIME_W-1:0]   rmax_time_ff, rmax_time_in;
   logic [TIME_W-1:0]   good_start_ff, good_start_in;
   logic [TIME_W-1:0]   good_dur_ff, good_dur_in;
   verdict_type         verdict_ff, verdict_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [TIME_W-1:0]   prev_ff, prev_in;
   logic [TIME_W-1:0]   last_ff, last_in;
   logic [TIME_W-1:0]   widest_ff, widest_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_ff, rsp_in;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [IDX_W-1:0]    rd_addr;
   logic [TIME_W-1:0]   rd_data;

   logic [TIME_W-1:0]   now, since_begin, since_quiet, silence_next, gap;
   logic [SAMPLE_W-1:0] rmax_next;
   logic [TIME_W-1:0]   rmax_time_next;
   logic [CMP_W-1:0]    peaks_x, req_x, cap_x;
   logic                seq_active, abort_c, check_c, peak, take, room;
   logic [SUM_W:0]      limit;

   irptv_ram #(
      .WIDTH (TIME_W),
      .DEPTH (MAX_PEAKS)
   ) u_stamps (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (rmax_time_next),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      now          = item_ff.time_ms;
      seq_active   = seq_begin_ff != '0;
      peaks_x      = CMP_W'(peaks_ff);
      req_x        = CMP_W'(cfg.required_peaks);
      cap_x        = (req_x < CMP_W'(MAX_PEAKS)) ? req_x : CMP_W'(MAX_PEAKS);
      room         = peaks_x < cap_x;
      since_begin  = now - seq_begin_ff;
      since_quiet  = now - silence_ff;
      abort_c      = seq_active && (peaks_x != req_x)
                     && (since_begin > TIME_W'(cfg.max_sequence_ms));
      check_c      = seq_active && (peaks_x == req_x) && (peaks_x != '0)
                     && (peaks_x <= CMP_W'(MAX_PEAKS)) && (silence_ff != '0)
                     && (since_quiet > TIME_W'(cfg.post_silence_ms));
      rmax_next      = (item_ff.sample > rmax_ff) ? item_ff.sample : rmax_ff;
      rmax_time_next = (item_ff.sample > rmax_ff) ? now : rmax_time_ff;
      peak         = !item_ff.lit && (rmax_next > cfg.level_threshold);
      take         = peak && (seq_active || (since_quiet > TIME_W'(cfg.pre_silence_ms)));
      silence_next = item_ff.lit ? '0 : ((silence_ff == '0) ? now : silence_ff);
      gap          = rd_data - prev_ff;
      limit        = (SUM_W+1)'(div_quot) + (SUM_W+1)'(cfg.gap_tolerance_ms);
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      peaks_in      = peaks_ff;
      seq_begin_in  = seq_begin_ff;
      silence_in    = silence_ff;
      rmax_in       = rmax_ff;
      rmax_time_in  = rmax_time_ff;
      good_start_in = good_start_ff;
      good_dur_in   = good_dur_ff;
      verdict_in    = verdict_ff;
      idx_in        = idx_ff;
      prev_in       = prev_ff;
      last_in       = last_ff;
      widest_in     = widest_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = IDX_W'(peaks_ff);
      rd_addr       = '0;
      div_start     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (abort_c) begin
               peaks_in     = '0;
               seq_begin_in = '0;
               verdict_in   = VERDICT_ABORTED;
               silence_in   = silence_next;
               state_in     = ST_DONE;
            end else if (check_c) begin
               // First stamp is being read now; the walk sees it next cycle.
               idx_in    = '0;
               sum_in    = '0;
               widest_in = '0;
               state_in  = ST_WALK;
            end else begin
               rmax_in      = peak ? '0 : rmax_next;
               rmax_time_in = rmax_time_next;
               if (take) begin
                  if (room) begin
                     wr_en    = 1'b1;
                     peaks_in = peaks_ff + 1'b1;
                     if (!seq_active) begin
                        seq_begin_in = rmax_time_next;
                     end
                  end else begin
                     // A further peak past the count drops the sequence.
                     peaks_in     = '0;
                     seq_begin_in = '0;
                  end
               end
               verdict_in = VERDICT_NONE;
               silence_in = silence_next;
               state_in   = ST_DONE;
            end
         end
         ST_WALK: begin
            rd_addr = idx_ff + 1'b1;
            prev_in = rd_data;
            if (idx_ff != '0) begin
               if (gap > widest_ff) begin
                  widest_in = gap;
               end
               sum_in = sum_ff + SUM_W'(gap);
            end
            if (CNT_W'(idx_ff) == peaks_ff - 1'b1) begin
               last_in  = rd_data;
               state_in = ST_DSTART;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DSTART: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               if ((SUM_W+1)'(widest_ff) > limit) begin
                  verdict_in = VERDICT_IRREGULAR;
               end else begin
                  good_dur_in   = last_ff - seq_begin_ff;
                  good_start_in = seq_begin_ff;
                  verdict_in    = VERDICT_ACCEPTED;
               end
               peaks_in     = '0;
               seq_begin_in = '0;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_in.verdict            = verdict_ff;
               rsp_in.accepted_start     = good_start_ff;
               rsp_in.accepted_duration  = good_dur_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         peaks_ff      <= '0;
         seq_begin_ff  <= '0;
         silence_ff    <= '0;
         rmax_ff       <= '0;
         rmax_time_ff  <= '0;
         good_start_ff <= '0;
         good_dur_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         peaks_ff      <= peaks_in;
         seq_begin_ff  <= seq_begin_in;
         silence_ff    <= silence_in;
         rmax_ff       <= rmax_in;
         rmax_time_ff  <= rmax_time_in;
         good_start_ff <= good_start_in;
         good_dur_ff   <= good_dur_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      verdict_ff <= verdict_in;
      idx_ff     <= idx_in;
      prev_ff    <= prev_in;
      last_ff    <= last_in;
      widest_ff  <= widest_in;
      sum_ff     <= sum_in;
      rsp_ff     <= rsp_in;
   end

   assign div_num    = sum_ff;
   assign div_den    = peaks_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule

### rtl/ir_pulse_train_validator_unit.sv
// Top level of the IR pulse train validator: registers, front, back and divider.
//
//   channel  direction  handshake            payload
//   req      in         req_tvalid/tready    tdata: sample[9:0], time_ms[41:10]
//   rsp      out        rsp_tvalid/tready    tdata: verdict[1:0], accepted_start[33:2],
//                                            accepted_duration[65:34]
//   csr      in         csr_valid/ready      csr_index, csr_data (register write)
//
// A sample without validation passes the back end in three steps (fetch,
// evaluate, result), and the back end takes no new sample before its result
// is in the result register. A validation makes P stamp reads, then one
// divider step for each of the SUM_W = 32 + count-width sum bits.
// A two-entry queue and the result register let the front and the back stall
// on their own. Reset restores the register defaults and clears all sequence
// state.
module ir_pulse_train_validator_unit #(
   parameter int MAX_PEAKS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // sample[9:0], time_ms[41:10], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // verdict[1:0], accepted_start[33:2],
                                    // accepted_duration[65:34], zero fill
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import irptv_pkg::*;

   localparam int CNT_W = $clog2(MAX_PEAKS + 1);
   localparam int SUM_W = TIME_W + CNT_W;

   cfg_type          cfg_ff, cfg_in;
   logic             q_valid;
   item_type         q_item;
   logic             q_pop;
   logic             div_start, div_busy, div_done;
   logic [SUM_W-1:0] div_num, div_quot;
   logic [CNT_W-1:0] div_den;
   result_type       rsp_result;

   // The user writes registers while the block is idle (unchecked); writes never stall.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LEVEL_THRESHOLD:  cfg_in.level_threshold  = csr_data[SAMPLE_W-1:0];
            CSR_PRE_SILENCE_MS:   cfg_in.pre_silence_ms   = csr_data;
            CSR_POST_SILENCE_MS:  cfg_in.post_silence_ms  = csr_data;
            CSR_MAX_SEQUENCE_MS:  cfg_in.max_sequence_ms  = csr_data;
            CSR_REQUIRED_PEAKS:   cfg_in.required_peaks   = csr_data[PEAKS_W-1:0];
            CSR_GAP_TOLERANCE_MS: cfg_in.gap_tolerance_ms = csr_data;
            default: begin
               // Indexes beyond the register list are ignored.
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_threshold  <= RST_LEVEL_THRESHOLD;
         cfg_ff.pre_silence_ms   <= RST_PRE_SILENCE_MS;
         cfg_ff.post_silence_ms  <= RST_POST_SILENCE_MS;
         cfg_ff.max_sequence_ms  <= RST_MAX_SEQUENCE_MS;
         cfg_ff.required_peaks   <= RST_REQUIRED_PEAKS;
         cfg_ff.gap_tolerance_ms <= RST_GAP_TOLERANCE_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front decides lit or quiet against the threshold and queues the request.
   irptv_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .level_threshold (cfg_ff.level_threshold),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   // The back runs the peak detector and the sequence rules, one request at a time.
   irptv_back #(
      .MAX_PEAKS (MAX_PEAKS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .div_start  (div_start),
      .div_num    (div_num),
      .div_den    (div_den),
      .div_done   (div_done),
      .div_quot   (div_quot),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (rsp_result)
   );

   // Mean gap: sum of gaps divided by the peak count.
   irptv_div #(
      .NUM_W (SUM_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_tdata = {6'b0, rsp_result.accepted_duration,
                       rsp_result.accepted_start, rsp_result.verdict};

   // The queue only refuses requests when it holds work for the back.
   a_queue_full_has_work: assert property (
      @(posedge clock) disable iff (reset) !req_tready |-> q_valid
   ) else $error("front refuses requests while its queue is empty");

   // An accepted sequence always had a nonzero start time.
   a_accept_has_start: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_result.verdict == VERDICT_ACCEPTED)
         |-> rsp_result.accepted_start != '0
   ) else $error("accepted sequence reported with zero start");

   // The divider is never restarted while it is still working.
   a_div_start_idle: assert property (
      @(posedge clock) disable iff (reset) div_start |-> !div_busy
   ) else $error("divider started while busy");

   // A quotient is only reported at the end of a running division.
   a_div_done_after_busy: assert property (
      @(posedge clock) disable iff (reset) div_done |-> $past(div_busy)
   ) else $error("divider done without a division in progress");

endmodule

### sim/ir_pulse_train_validator_unit_tb.sv
// Self-checking testbench of the IR pulse train validator: stream stimulus, predictor, checks.
module ir_pulse_train_validator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import irptv_pkg::*;

   localparam int PEAK_SLOTS     = 8;
   localparam int PHASE_COUNT    = 8;
   localparam int WATCHDOG_LIMIT = 4000;

   // Number of random requests in each configuration phase. Phase five has
   // nothing above threshold, so it is kept short.
   localparam int PHASE_ITEMS [PHASE_COUNT] = '{280, 280, 280, 280, 280, 60, 280, 280};

   // Directed requests, each {time_ms, sample}, sent with the reset settings.
   // They cover the field extremes, a peak stamped at time zero that leaves
   // the sequence start at none, a sample exactly at threshold, an irregular
   // train, an accepted train, a surplus peak that drops the sequence, and a
   // sequence aborted for running too long.
   localparam logic [41:0] DIRECTED [26] = '{
      {32'hFFFF_FFFF, 10'd0},    {32'd0, 10'd1023},     {32'd2000, 10'd0},
      {32'd2100, 10'd1023},      {32'd2101, 10'd5},     {32'd2300, 10'd1000},
      {32'd2301, 10'd990},       {32'd3400, 10'd0},     {32'd10000, 10'd1023},
      {32'd10001, 10'd0},        {32'd10300, 10'd991},  {32'd10301, 10'd0},
      {32'd10600, 10'd1023},     {32'd10601, 10'd0},    {32'd11700, 10'd0},
      {32'd20000, 10'd1023},     {32'd20001, 10'd0},    {32'd20100, 10'd1023},
      {32'd20101, 10'd0},        {32'd20200, 10'd1023}, {32'd20201, 10'd0},
      {32'd20300, 10'd1023},     {32'd20301, 10'd0},    {32'd30000, 10'd1023},
      {32'd30001, 10'd0},        {32'd31500, 10'd0}
   };

   typedef enum int {
      TRAIN_REGULAR,
      TRAIN_IRREGULAR,
      TRAIN_EXTRA_PEAK,
      TRAIN_SLOW,
      TRAIN_SHORT
   } train_kind_type;

   // Scoreboard: mirrors the validator state, predicts one report per
   // accepted request and compares the reports that come back in order.
   class pulse_train_scoreboard;
      cfg_type             settings;
      logic [TIME_W-1:0]   stamp [PEAK_SLOTS];
      int unsigned         stamp_count;
      logic [TIME_W-1:0]   train_start;
      logic [TIME_W-1:0]   dark_since;
      logic [SAMPLE_W-1:0] crest;
      logic [TIME_W-1:0]   crest_time;
      logic [TIME_W-1:0]   good_start;
      logic [TIME_W-1:0]   good_length;
      result_type          reports_due [$];
      int                  failures;

      function new();
         settings.level_threshold  = RST_LEVEL_THRESHOLD;
         settings.pre_silence_ms   = RST_PRE_SILENCE_MS;
         settings.post_silence_ms  = RST_POST_SILENCE_MS;
         settings.max_sequence_ms  = RST_MAX_SEQUENCE_MS;
         settings.required_peaks   = RST_REQUIRED_PEAKS;
         settings.gap_tolerance_ms = RST_GAP_TOLERANCE_MS;
         foreach (stamp[i]) stamp[i] = '0;
         stamp_count = 0;
         train_start = '0;
         dark_since  = '0;
         crest       = '0;
         crest_time  = '0;
         good_start  = '0;
         good_length = '0;
         failures    = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_LEVEL_THRESHOLD:  settings.level_threshold  = value[SAMPLE_W-1:0];
            CSR_PRE_SILENCE_MS:   settings.pre_silence_ms   = value[MS_W-1:0];
            CSR_POST_SILENCE_MS:  settings.post_silence_ms  = value[MS_W-1:0];
            CSR_MAX_SEQUENCE_MS:  settings.max_sequence_ms  = value[MS_W-1:0];
            CSR_REQUIRED_PEAKS:   settings.required_peaks   = value[PEAKS_W-1:0];
            CSR_GAP_TOLERANCE_MS: settings.gap_tolerance_ms = value[MS_W-1:0];
            default: ;
         endcase
      endfunction

      function void drop_train();
         stamp_count = 0;
         train_start = '0;
      endfunction

      // A peak beyond the required count or slot limit ends the sequence without a verdict.
      function void store_stamp(logic [TIME_W-1:0] at_ms, int unsigned cap);
         if (stamp_count < cap) begin
            stamp[stamp_count] = at_ms;
            stamp_count++;
         end else begin
            drop_train();
         end
      endfunction

      function void note_request(logic [SAMPLE_W-1:0] smp, logic [TIME_W-1:0] now);
         result_type        due;
         int unsigned       cap;
         bit                validated;
         bit                peak;
         logic [TIME_W-1:0] since_start;
         logic [TIME_W-1:0] since_dark;
         logic [TIME_W-1:0] gap;
         logic [63:0]       gap_sum;
         logic [63:0]       widest;
         logic [63:0]       mean;
         cap = (settings.required_peaks < PEAK_SLOTS) ? settings.required_peaks : PEAK_SLOTS;
         validated   = 1'b0;
         peak        = 1'b0;
         due.verdict = VERDICT_NONE;
         // Both differences wrap at 32 bits.
         since_start = now - train_start;
         since_dark  = now - dark_since;
         if (train_start != 0 && stamp_count != settings.required_peaks &&
             since_start > settings.max_sequence_ms) begin
            drop_train();
            due.verdict = VERDICT_ABORTED;
         end else if (train_start != 0 && stamp_count == settings.required_peaks &&
                      stamp_count != 0 && stamp_count <= PEAK_SLOTS && dark_since != 0 &&
                      since_dark > settings.post_silence_ms) begin
            gap_sum = '0;
            widest  = '0;
            for (int c = 1; c < stamp_count; c++) begin
               gap = stamp[c] - stamp[c-1];
               if (gap > widest) widest = gap;
               gap_sum += gap;
            end
            // The mean divides by the peak count, not by the gap count.
            mean = gap_sum / stamp_count;
            if (widest > mean + settings.gap_tolerance_ms) begin
               due.verdict = VERDICT_IRREGULAR;
            end else begin
               good_length = stamp[stamp_count-1] - train_start;
               good_start  = train_start;
               due.verdict = VERDICT_ACCEPTED;
            end
            drop_train();
            validated = 1'b1;
         end else begin
            if (smp > crest) begin
               crest      = smp;
               crest_time = now;
            end
            if (smp <= settings.level_threshold && crest > settings.level_threshold) begin
               crest = '0;
               peak  = 1'b1;
            end
            if (peak) begin
               if (train_start == 0) begin
                  if (since_dark > settings.pre_silence_ms) begin
                     store_stamp(crest_time, cap);
                     if (stamp_count != 0) train_start = crest_time;
                  end
               end else begin
                  store_stamp(crest_time, cap);
               end
            end
         end
         // Quiet tracking is skipped on the sample that triggered a validation.
         if (!validated) begin
            if (smp > settings.level_threshold) dark_since = '0;
            else if (dark_since == 0) dark_since = now;
         end
         due.accepted_start    = good_start;
         due.accepted_duration = good_length;
         reports_due.push_back(due);
      endfunction

      function void check_result(logic [71:0] word);
         result_type want;
         if (reports_due.size() == 0) begin
            $error("report with no request waiting: verdict %0d", word[1:0]);
            failures++;
         end else begin
            want = reports_due.pop_front();
            if (word[1:0] !== want.verdict) begin
               $error("verdict: expected %0d, actual %0d", want.verdict, word[1:0]);
               failures++;
            end
            if (word[33:2] !== want.accepted_start) begin
               $error("accepted_start: expected %0d, actual %0d",
                      want.accepted_start, word[33:2]);
               failures++;
            end
            if (word[65:34] !== want.accepted_duration) begin
               $error("accepted_duration: expected %0d, actual %0d",
                      want.accepted_duration, word[65:34]);
               failures++;
            end
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;   // sample[9:0], time_ms[41:10], zero fill
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;         // verdict[1:0], accepted_start[33:2],
                                   // accepted_duration[65:34], zero fill
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index  = '0;
   logic [15:0] csr_data   = '0;

   pulse_train_scoreboard sb;
   logic [TIME_W-1:0]     clock_ms;
   int unsigned           samples_sent = 0;
   int                    idle_pct     = 0;
   int                    stall_left   = 0;
   int                    quiet_cycles = 0;

   ir_pulse_train_validator_unit #(
      .MAX_PEAKS(PEAK_SLOTS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Result side. Reports are checked at the edge that accepts them, and the
   // ready line is dropped in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < idle_pct) begin
            stall_left <= $urandom_range(0, 15);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // The run ends as a failure when no handshake of any channel happens for
   // far longer than the slowest validation and the longest stall together.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Sends one sample request, sometimes after a random idle burst, and
   // records it with the scoreboard at the edge that accepts it. Valid stays
   // high on return so that back-to-back requests need no extra step.
   task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic [TIME_W-1:0] at_ms);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, at_ms, smp};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(smp, at_ms);
      samples_sent++;
   endtask

   // Valid is left high between writes and lowered by the caller after the
   // last one of a batch.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(idx, value);
   endtask

   task automatic apply_settings(input cfg_type c);
      write_register(CSR_LEVEL_THRESHOLD, CSR_DATA_W'(c.level_threshold));
      write_register(CSR_PRE_SILENCE_MS, c.pre_silence_ms);
      write_register(CSR_POST_SILENCE_MS, c.post_silence_ms);
      write_register(CSR_MAX_SEQUENCE_MS, c.max_sequence_ms);
      write_register(CSR_REQUIRED_PEAKS, CSR_DATA_W'(c.required_peaks));
      write_register(CSR_GAP_TOLERANCE_MS, c.gap_tolerance_ms);
      csr_valid <= 1'b0;
   endtask

   // Stops requests and waits until every predicted report has come back,
   // then lets the back end settle before the registers change.
   task automatic drain_reports();
      req_tvalid <= 1'b0;
      while (sb.reports_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] lit_level();
      int unsigned thr;
      thr = sb.settings.level_threshold;
      return (thr >= 1023) ? 10'd1023 : SAMPLE_W'($urandom_range(thr + 1, 1023));
   endfunction

   function automatic logic [SAMPLE_W-1:0] quiet_level();
      return SAMPLE_W'($urandom_range(0, sb.settings.level_threshold));
   endfunction

   // Settings of each random phase. They reach the extremes of every
   // register, including peak counts of zero, one and above the slot limit.
   function automatic cfg_type phase_settings(int phase);
      cfg_type c;
      case (phase)
         0: c = '{level_threshold: 10'd512, pre_silence_ms: 16'd20, post_silence_ms: 16'd30,
                  max_sequence_ms: 16'd400, required_peaks: 4'd2, gap_tolerance_ms: 16'd0};
         1: c = '{level_threshold: 10'd0, pre_silence_ms: 16'd0, post_silence_ms: 16'd0,
                  max_sequence_ms: 16'd0, required_peaks: 4'd8, gap_tolerance_ms: 16'hFFFF};
         2: c = '{level_threshold: 10'd1022, pre_silence_ms: 16'hFFFF,
                  post_silence_ms: 16'hFFFF, max_sequence_ms: 16'hFFFF,
                  required_peaks: 4'd15, gap_tolerance_ms: 16'hFFFF};
         3: c = '{level_threshold: 10'd700, pre_silence_ms: 16'd100, post_silence_ms: 16'd200,
                  max_sequence_ms: 16'd2000, required_peaks: 4'd8, gap_tolerance_ms: 16'd40};
         4: c = '{level_threshold: 10'd300, pre_silence_ms: 16'hFFFF,
                  post_silence_ms: 16'hFFFF, max_sequence_ms: 16'hFFFF,
                  required_peaks: 4'd5, gap_tolerance_ms: 16'd1000};
         5: c = '{level_threshold: 10'd1023, pre_silence_ms: 16'd50, post_silence_ms: 16'd50,
                  max_sequence_ms: 16'd500, required_peaks: 4'd0, gap_tolerance_ms: 16'd100};
         6: c = '{level_threshold: 10'd600, pre_silence_ms: 16'd10, post_silence_ms: 16'd10,
                  max_sequence_ms: 16'd300, required_peaks: 4'd1, gap_tolerance_ms: 16'd5};
         default: c = '{level_threshold: RST_LEVEL_THRESHOLD,
                        pre_silence_ms: RST_PRE_SILENCE_MS,
                        post_silence_ms: RST_POST_SILENCE_MS,
                        max_sequence_ms: RST_MAX_SEQUENCE_MS,
                        required_peaks: RST_REQUIRED_PEAKS,
                        gap_tolerance_ms: RST_GAP_TOLERANCE_MS};
      endcase
      return c;
   endfunction

   // One pulse train shaped by the current settings: a quiet lead-in longer
   // than the pre-silence time, a series of peaks of one to three lit
   // samples each, and a quiet tail long enough to trigger validation. Most
   // trains are regular; the rest have one wide gap, a surplus peak, gaps
   // longer than the sequence limit, or a missing peak.
   task automatic send_train();
      train_kind_type kind;
      int unsigned    pick;
      int unsigned    peaks;
      int unsigned    span;
      int unsigned    base;
      int unsigned    gap;
      int unsigned    half;
      int unsigned    odd_gap;
      pick = $urandom_range(0, 9);
      if (pick < 6) kind = TRAIN_REGULAR;
      else if (pick == 6) kind = TRAIN_IRREGULAR;
      else if (pick == 7) kind = TRAIN_EXTRA_PEAK;
      else if (pick == 8) kind = TRAIN_SLOW;
      else kind = TRAIN_SHORT;

      peaks = sb.settings.required_peaks;
      if (peaks == 0 || peaks > PEAK_SLOTS) peaks = $urandom_range(1, PEAK_SLOTS);
      if (kind == TRAIN_EXTRA_PEAK) peaks++;
      if (kind == TRAIN_SHORT && peaks > 1) peaks--;
      span    = sb.settings.max_sequence_ms / peaks;
      base    = $urandom_range(4, (span > 24) ? span - 12 : 12);
      odd_gap = $urandom_range(0, (peaks > 1) ? peaks - 2 : 0);

      clock_ms += 1;
      send_sample(quiet_level(), clock_ms);
      clock_ms += sb.settings.pre_silence_ms + $urandom_range(1, 20);
      send_sample(quiet_level(), clock_ms);

      for (int k = 0; k < peaks; k++) begin
         repeat ($urandom_range(1, 3)) begin
            clock_ms += $urandom_range(1, 3);
            send_sample(lit_level(), clock_ms);
         end
         clock_ms += 1;
         send_sample(quiet_level(), clock_ms);
         if (k + 1 < peaks) begin
            gap = base + $urandom_range(0, 3);
            if (kind == TRAIN_IRREGULAR && k == odd_gap)
               gap = 2 * base + sb.settings.gap_tolerance_ms + $urandom_range(1, 50);
            if (kind == TRAIN_SLOW)
               gap = sb.settings.max_sequence_ms + $urandom_range(1, 64);
            // Now and then a quiet sample falls inside the gap.
            half = ($urandom_range(0, 3) == 0) ? gap / 2 : 0;
            if (half != 0) begin
               clock_ms += half;
               send_sample(quiet_level(), clock_ms);
            end
            clock_ms += gap - half;
         end
      end

      if (kind == TRAIN_SHORT)
         clock_ms += sb.settings.max_sequence_ms + $urandom_range(1, 20);
      else
         clock_ms += sb.settings.post_silence_ms + $urandom_range(1, 20);
      send_sample(quiet_level(), clock_ms);
      clock_ms += 1;
      send_sample(quiet_level(), clock_ms);
   endtask

   // A short burst of unrelated samples, with time jumps to anywhere,
   // to zero and to the last value before the wrap.
   task automatic send_noise();
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(0, 9))
            0: clock_ms = $urandom;
            1: clock_ms = '0;
            2: clock_ms = '1;
            default: clock_ms += $urandom_range(0, 40);
         endcase
         send_sample(SAMPLE_W'($urandom_range(0, 1023)), clock_ms);
      end
   endtask

   // Main sequence: reset, directed requests on the reset settings, then one
   // random phase per group of settings, each ended by a full drain so that
   // the registers only change while the block is idle. The last phase runs
   // without idle bursts on either side.
   initial begin
      int unsigned phase_end;
      sb = new();
      clock_ms = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_pct = 25;
      foreach (DIRECTED[i]) send_sample(DIRECTED[i][9:0], DIRECTED[i][41:10]);
      drain_reports();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         apply_settings(phase_settings(phase));
         idle_pct  = (phase == PHASE_COUNT - 1) ? 0 : 20 * $urandom_range(0, 2);
         // Some phases start just below the wrap of the millisecond counter.
         clock_ms  = ($urandom_range(0, 1) != 0) ? $urandom : 32'hFFFF_F000;
         phase_end = samples_sent + PHASE_ITEMS[phase];
         while (samples_sent < phase_end) begin
            if ($urandom_range(0, 3) == 0) send_noise();
            else send_train();
         end
         drain_reports();
      end

      repeat (60) @(posedge clock);
      if (sb.failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### files.f
rtl/irptv_pkg.sv
rtl/irptv_ram.sv
rtl/irptv_front.sv
rtl/irptv_div.sv
rtl/irptv_back.sv
rtl/ir_pulse_train_validator_unit.sv
sim/ir_pulse_train_validator_unit_tb.sv
